[rtl/core/scc_pkg.sv]
// Shared constants and types for the strongly connected components core.
// No dependencies.
package scc_pkg;
  localparam int MaxNodes = 64;
  localparam int NodeW = 6;
  localparam int CountW = 7;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [CountW-1:0] pos;
    logic [NodeW-1:0]  node;
  } frame_t;
endpackage

[rtl/core/strongly_connected_components_core.sv]
// Top level: Tarjan SCC over an adjacency bit matrix held in a synchronous RAM.
// Depends on scc_pkg.
//
// channel | dir | tdata fields (low bit first)                 | tuser/tlast
// in_     | in  | operation[1:0] source_node[7:2] target[13:8] | -
// out_    | out | node_id[5:0] component_id[11:6] total[18:12]  | tlast=last_result
// cfg_    | in  | node_count[6:0]                              | -
//
// Add edge steps through accept, row read and row write. Clear sweeps 64 rows, one per
// cycle, after the accept. Compute runs the Tarjan walk over the N nodes, then streams N results.
// rst_n clears the matrix with a sweep of all 64 rows during which no request is taken.
// The output holds a result while out_tready is low; the result stream waits.
module strongly_connected_components_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operation, source_node, target_node
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // node_id, component_id, component_total
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // node_count
);
  import scc_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_RD, S_ADD_WR, S_INIT, S_ROOT, S_RD, S_SCAN, S_BACK, S_POP,
    S_RET, S_RLL, S_OUT
  } state_t;

  state_t state_r;
  logic [MaxNodes-1:0] adj_mem [MaxNodes];
  logic [MaxNodes-1:0] adj_q;
  logic [NodeW-1:0]    adj_ra;
  logic [NodeW-1:0]    vo_mem [MaxNodes];
  logic [NodeW-1:0]    ll_mem [MaxNodes];
  logic [NodeW-1:0]    comp_mem [MaxNodes];
  logic [NodeW-1:0]    ns_mem [MaxNodes];
  frame_t              cs_mem [MaxNodes];
  logic [NodeW-1:0]    vo_q, ll_q, ns_q, comp_q;
  frame_t              cs_q;
  logic [NodeW-1:0]    vo_ra, ns_ra, cs_ra, comp_ra;
  logic                out_step;
  logic [MaxNodes-1:0] visited_r, onstk_r;
  logic [CountW-1:0]   node_count_r, n_r, nst_r, cd_r, nv_r, cc_r, root_r, i_r;
  logic [NodeW-1:0]    v_r, src_r, tgt_r;
  logic [CountW-1:0]   pos_r;
  logic [NodeW-1:0]    llv_r, vov_r;
  logic                outv_r, last_r;
  logic [23:0]         outd_r;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = outv_r;
  assign out_tdata = outd_r;
  assign out_tlast = last_r;

  logic [MaxNodes-1:0] mask, cand;
  logic [NodeW-1:0]    w;
  logic                found;
  always_comb begin
    mask = '0;
    cand = '0;
    w = '0;
    found = 1'b0;
    for (int k = 0; k < MaxNodes; k++) begin
      mask[k] = (k >= pos_r) && (k < n_r);
    end
    cand = adj_q & mask;
    for (int k = MaxNodes - 1; k >= 0; k--) begin
      if (cand[k]) begin
        w = NodeW'(k);
        found = 1'b1;
      end
    end
  end

  // read addresses look one step ahead where the pointer moves in the same cycle
  assign out_step = (state_r == S_OUT) && (!outv_r || out_tready) && (i_r != n_r);
  always_comb begin
    vo_ra = (state_r == S_RET) ? cs_q.node : w;
    ns_ra = nst_r[NodeW-1:0] - ((state_r == S_POP) ? NodeW'(2) : NodeW'(1));
    cs_ra = cd_r[NodeW-1:0] - ((state_r == S_SCAN) ? NodeW'(2) : NodeW'(1));
    comp_ra = i_r[NodeW-1:0] + NodeW'(out_step);
  end

  always_ff @(posedge clk) begin
    adj_q <= adj_mem[adj_ra];
    vo_q <= vo_mem[vo_ra];
    ll_q <= ll_mem[cs_q.node];
    ns_q <= ns_mem[ns_ra];
    cs_q <= cs_mem[cs_ra];
    comp_q <= comp_mem[comp_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      node_count_r <= 7'd64;
      i_r <= '0;
      outv_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) node_count_r <= cfg_data[CountW-1:0];
      case (state_r)
        S_CLR: begin
          adj_mem[i_r[NodeW-1:0]] <= '0;
          i_r <= i_r + 1'b1;
          if (i_r == CountW'(MaxNodes - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          i_r <= '0;
          if (in_tvalid) begin
            src_r <= in_tdata[7:2];
            tgt_r <= in_tdata[13:8];
            adj_ra <= in_tdata[7:2];
            case (op_t'(in_tdata[1:0]))
              OP_ADD:   state_r <= S_ADD_RD;
              OP_CLEAR: state_r <= S_CLR;
              OP_RUN:   state_r <= S_INIT;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_ADD_RD: state_r <= S_ADD_WR;
        S_ADD_WR: begin
          adj_mem[src_r] <= adj_q | (MaxNodes'(1) << tgt_r);
          state_r <= S_IDLE;
        end
        S_INIT: begin
          n_r <= (node_count_r == 0) ? 7'd1 :
                 (node_count_r > 7'd64) ? 7'd64 : node_count_r;
          visited_r <= '0;
          onstk_r <= '0;
          nst_r <= '0;
          cd_r <= '0;
          nv_r <= '0;
          cc_r <= '0;
          root_r <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (root_r == n_r) begin
            i_r <= '0;
            state_r <= S_OUT;
          end else if (visited_r[root_r[NodeW-1:0]]) begin
            root_r <= root_r + 1'b1;
          end else begin
            v_r <= root_r[NodeW-1:0];
            pos_r <= '0;
            llv_r <= nv_r[NodeW-1:0];
            vov_r <= nv_r[NodeW-1:0];
            visited_r[root_r[NodeW-1:0]] <= 1'b1;
            onstk_r[root_r[NodeW-1:0]] <= 1'b1;
            vo_mem[root_r[NodeW-1:0]] <= nv_r[NodeW-1:0];
            ns_mem[nst_r[NodeW-1:0]] <= root_r[NodeW-1:0];
            nst_r <= nst_r + 1'b1;
            nv_r <= nv_r + 1'b1;
            cd_r <= 7'd1;
            adj_ra <= root_r[NodeW-1:0];
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_SCAN;
        S_SCAN: begin
          if (found) begin
            if (!visited_r[w]) begin
              cs_mem[cd_r[NodeW-1:0] - 1'b1] <= '{pos: CountW'(w) + 1'b1, node: v_r};
              ll_mem[v_r] <= llv_r;
              v_r <= w;
              pos_r <= '0;
              llv_r <= nv_r[NodeW-1:0];
              vov_r <= nv_r[NodeW-1:0];
              visited_r[w] <= 1'b1;
              onstk_r[w] <= 1'b1;
              vo_mem[w] <= nv_r[NodeW-1:0];
              ns_mem[nst_r[NodeW-1:0]] <= w;
              nst_r <= nst_r + 1'b1;
              nv_r <= nv_r + 1'b1;
              cd_r <= cd_r + 1'b1;
              adj_ra <= w;
              state_r <= S_RD;
            end else begin
              pos_r <= CountW'(w) + 1'b1;
              if (onstk_r[w]) state_r <= S_BACK;
            end
          end else begin
            cd_r <= cd_r - 1'b1;
            ll_mem[v_r] <= llv_r;
            state_r <= (llv_r == vov_r) ? S_POP : S_RET;
          end
        end
        S_BACK: begin
          if (vo_q < llv_r) llv_r <= vo_q;
          state_r <= S_SCAN;
        end
        S_POP: begin
          nst_r <= nst_r - 1'b1;
          onstk_r[ns_q] <= 1'b0;
          comp_mem[ns_q] <= cc_r[NodeW-1:0];
          if (ns_q == v_r || nst_r == 7'd1) begin
            cc_r <= cc_r + 1'b1;
            state_r <= S_RET;
          end
        end
        S_RET: begin
          if (cd_r == 0) begin
            root_r <= root_r + 1'b1;
            state_r <= S_ROOT;
          end else begin
            v_r <= cs_q.node;
            pos_r <= cs_q.pos;
            adj_ra <= cs_q.node;
            state_r <= S_RLL;
          end
        end
        S_RLL: begin
          if (ll_q < llv_r) llv_r <= ll_q;
          vov_r <= vo_q;
          state_r <= S_SCAN;
        end
        S_OUT: begin
          if (!outv_r || out_tready) begin
            if (i_r == n_r) begin
              outv_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              outv_r <= 1'b1;
              outd_r <= {5'd0, cc_r, comp_q, i_r[NodeW-1:0]};
              last_r <= (i_r + 1'b1 == n_r);
              i_r <= i_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[verif/tb_strongly_connected_components_core.sv]
// Testbench for strongly_connected_components_core: loads graphs, runs SCC computes
// and checks each streamed node result against an in-bench Tarjan predictor.
// Depends on scc_pkg and the core RTL.
module tb_strongly_connected_components_core;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  typedef struct packed {
    logic [5:0] node_id;
    logic [5:0] comp_id;
    logic [6:0] comp_total;
    logic       last;
  } node_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // operation[1:0], source_node[7:2], target_node[13:8]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // node_id[5:0], component_id[11:6], component_total[18:12]
  logic        out_tlast;  // last_result
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;   // node_count

  strongly_connected_components_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [63:0]  graph_rows [64];
  logic [6:0]   node_count_q;
  node_result_t pending_results[$];

  int  errors;
  int  idle_pct;
  bit  rx_hold;
  int  quiet_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic void predict_components();
    int  n, sp, depth, nxt, ncomp, v, w, u, x;
    bit  seen[64], on_stk[64];
    int  order[64], low[64], comp[64], stk[64], frame_node[64], frame_pos[64];
    node_result_t r;
    n = node_count_q;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    sp = 0; depth = 0; nxt = 0; ncomp = 0;
    foreach (seen[i]) begin seen[i] = 0; on_stk[i] = 0; end
    for (int root = 0; root < n; root++) begin
      if (seen[root]) continue;
      seen[root] = 1; order[root] = nxt; low[root] = nxt; nxt++;
      stk[sp] = root; sp++; on_stk[root] = 1;
      frame_node[depth] = root; frame_pos[depth] = 0; depth++;
      while (depth > 0) begin
        v = frame_node[depth-1];
        w = frame_pos[depth-1];
        while (w < n && !graph_rows[v][w]) w++;
        if (w < n) begin
          frame_pos[depth-1] = w + 1;
          if (!seen[w]) begin
            seen[w] = 1; order[w] = nxt; low[w] = nxt; nxt++;
            stk[sp] = w; sp++; on_stk[w] = 1;
            frame_node[depth] = w; frame_pos[depth] = 0; depth++;
          end else if (on_stk[w] && order[w] < low[v]) begin
            low[v] = order[w];
          end
          continue;
        end
        depth--;
        if (low[v] == order[v]) begin
          do begin
            sp--; x = stk[sp]; on_stk[x] = 0; comp[x] = ncomp;
          end while (x != v && sp > 0);
          ncomp++;
        end
        if (depth > 0) begin
          u = frame_node[depth-1];
          if (low[v] < low[u]) low[u] = low[v];
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node_id = 6'(i); r.comp_id = 6'(comp[i]); r.comp_total = 7'(ncomp);
      r.last = (i == n - 1);
      pending_results.push_back(r);
    end
  endfunction

  task automatic send_request(op_t op, int src, int dst);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {2'b00, dst[5:0], src[5:0], op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (op)
      OP_ADD:   graph_rows[src[5:0]][dst[5:0]] = 1;
      OP_CLEAR: foreach (graph_rows[i]) graph_rows[i] = '0;
      OP_RUN:   predict_components();
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_node_count(int value);
    drain_results();
    cfg_valid <= 1;
    cfg_data  <= 8'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    node_count_q = 7'(value);
    cfg_valid <= 0;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    node_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[5:0], out_tdata[11:6], out_tdata[18:12], out_tlast};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display({"%0t mismatch: expected node %0d comp %0d total %0d last %0b, ",
                    "actual node %0d comp %0d total %0d last %0b"},
                   $time, want.node_id, want.comp_id, want.comp_total, want.last,
                   got.node_id, got.comp_id, got.comp_total, got.last);
          errors++;
        end
      end
    end
    out_tready <= !rx_hold && !(idle_pct > 0 && $urandom_range(99) < idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || (pending_results.size() == 0 && !in_tvalid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 50000) begin
      $display("tb_strongly_connected_components_core NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_RUN, 0, 0);               // empty graph, 64 singletons
    write_node_count(1);
    send_request(OP_RUN, 0, 0);
    send_request(OP_ADD, 0, 0);               // self loop
    send_request(OP_RUN, 0, 0);
    write_node_count(6);
    send_request(OP_ADD, 0, 1);
    send_request(OP_ADD, 1, 2);
    send_request(OP_ADD, 2, 0);
    send_request(OP_ADD, 2, 0);               // duplicate
    send_request(OP_ADD, 3, 4);
    send_request(OP_ADD, 4, 3);
    send_request(OP_ADD, 5, 63);              // beyond node count
    send_request(OP_ADD, 63, 5);
    send_request(OP_RUN, 0, 0);
    send_request(OP_NONE, 63, 63);
    write_node_count(64);
    send_request(OP_ADD, 63, 0);
    send_request(OP_ADD, 0, 63);
    send_request(OP_RUN, 0, 0);
    send_request(OP_CLEAR, 0, 0);
    write_node_count(0);
    send_request(OP_RUN, 0, 0);
    write_node_count(127);
    send_request(OP_RUN, 21, 42);
  endtask

  task automatic test_random_graphs(int items);
    int  sent, ncnt, nedges;
    sent = 0;
    while (sent < items) begin
      ncnt = ($urandom_range(7) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
      write_node_count(ncnt);
      if ($urandom_range(3) != 0) begin
        send_request(OP_CLEAR, $urandom, $urandom);
        sent++;
      end
      nedges = $urandom_range(0, 2 * ncnt + 2);
      for (int e = 0; e < nedges; e++) begin
        if ($urandom_range(19) == 0)
          send_request(OP_ADD, $urandom_range(63), $urandom_range(63));
        else
          send_request(OP_ADD, $urandom_range(ncnt - 1), $urandom_range(ncnt - 1));
        sent++;
      end
      if ($urandom_range(15) == 0) send_request(OP_NONE, $urandom, $urandom);
      send_request(OP_RUN, $urandom, $urandom);
      sent++;
    end
  endtask

  task automatic test_output_backpressure();
    write_node_count(40);
    fork
      begin
        rx_hold = 1;
        repeat (600) @(posedge clk);
        rx_hold = 0;
      end
      begin
        send_request(OP_RUN, 0, 0);
        for (int i = 0; i < 20; i++) send_request(OP_ADD, $urandom_range(39), $urandom_range(39));
        send_request(OP_RUN, 0, 0);
        drain_results();
      end
    join
  endtask

  initial begin
    errors = 0; idle_pct = 32; rx_hold = 0; quiet_cycles = 0;
    node_count_q = 64;
    foreach (graph_rows[i]) graph_rows[i] = '0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0; cfg_valid = 0; cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    test_directed();
    test_random_graphs(160);
    idle_pct = 0;                              // stretch with no idling
    test_random_graphs(70);
    idle_pct = 32;
    test_random_graphs(110);
    test_output_backpressure();
    drain_results();
    if (errors == 0)
      $display("tb_strongly_connected_components_core OK");
    else
      $display("tb_strongly_connected_components_core NOT OK");
    $finish;
  end
endmodule

[sim.f]
rtl/core/scc_pkg.sv
rtl/core/strongly_connected_components_core.sv
verif/tb_strongly_connected_components_core.sv
